FILE: design/xcpd_pkg.sv
package xcpd_pkg;

    localparam int PAYLOAD_DEPTH = 256;
    localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [8:0] DEPTH_9 = 9'(PAYLOAD_DEPTH);

    typedef enum logic [1:0] {
        CMD_FEED  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_COMMAND  = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_PAYLOAD  = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_FINISHED = 3'd4,
        ST_FAILED   = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
        logic       read_valid;
    } meta_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

endpackage

FILE: design/xcpd_parser.sv
module xcpd_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [1:0]            cmd,
    input  logic [7:0]            byte_in,
    input  logic [7:0]            read_index,
    output xcpd_pkg::meta_t       meta,
    output xcpd_pkg::store_req_t  store_req
);

    typedef enum logic [5:0] {
        PH_COMMAND  = 6'b000001,
        PH_LENGTH   = 6'b000010,
        PH_PAYLOAD  = 6'b000100,
        PH_CHECKSUM = 6'b001000,
        PH_FINISHED = 6'b010000,
        PH_FAILED   = 6'b100000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] pos;
    logic [7:0] left_dec;
    logic       read_hit;
    xcpd_pkg::status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_COMMAND;
            command_reg <= 8'd0;
            length_reg  <= 8'd0;
            left_reg    <= 8'd0;
            xor_reg     <= 8'd0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            left_reg    <= left_next;
            xor_reg     <= xor_next;
        end
    end

    assign pos      = length_reg - left_reg;
    assign left_dec = (left_reg != 8'd0) ? left_reg - 8'd1 : left_reg;

    always_comb begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        xor_next     = xor_reg;
        read_hit     = 1'b0;
        store_req.wr_en   = 1'b0;
        store_req.wr_addr = pos[xcpd_pkg::ADDR_W-1:0];
        store_req.wr_data = byte_in;
        store_req.rd_addr = read_index[xcpd_pkg::ADDR_W-1:0];
        case (xcpd_pkg::cmd_t'(cmd))
            xcpd_pkg::CMD_FEED: begin
                case (phase_reg)
                    PH_COMMAND: begin
                        command_next = byte_in;
                        xor_next     = xor_reg ^ byte_in;
                        phase_next   = PH_LENGTH;
                    end
                    PH_LENGTH: begin
                        length_next = byte_in;
                        left_next   = byte_in;
                        xor_next    = xor_reg ^ byte_in;
                        if ({1'b0, byte_in} > xcpd_pkg::DEPTH_9) begin
                            phase_next = PH_FAILED;
                        end else if (byte_in == 8'd0) begin
                            phase_next = PH_CHECKSUM;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        store_req.wr_en = ({1'b0, pos} < xcpd_pkg::DEPTH_9);
                        xor_next  = xor_reg ^ byte_in;
                        left_next = left_dec;
                        if (left_dec == 8'd0) begin
                            phase_next = PH_CHECKSUM;
                        end
                    end
                    PH_CHECKSUM: begin
                        phase_next = (xor_reg == byte_in) ? PH_FINISHED : PH_FAILED;
                    end
                    default: begin
                    end
                endcase
            end
            xcpd_pkg::CMD_CLEAR: begin
                phase_next   = PH_COMMAND;
                command_next = 8'd0;
                length_next  = 8'd0;
                left_next    = 8'd0;
                xor_next     = 8'd0;
            end
            xcpd_pkg::CMD_READ: begin
                read_hit = (phase_reg == PH_FINISHED) && (read_index < length_reg)
                           && ({1'b0, read_index} < xcpd_pkg::DEPTH_9);
            end
            default: begin
            end
        endcase
        store_req.rd_en = read_hit;
    end

    always_comb begin
        case (phase_next)
            PH_COMMAND:  status = xcpd_pkg::ST_COMMAND;
            PH_LENGTH:   status = xcpd_pkg::ST_LENGTH;
            PH_PAYLOAD:  status = xcpd_pkg::ST_PAYLOAD;
            PH_CHECKSUM: status = xcpd_pkg::ST_CHECKSUM;
            PH_FINISHED: status = xcpd_pkg::ST_FINISHED;
            default:     status = xcpd_pkg::ST_FAILED;
        endcase
    end

    assign meta.status        = status;
    assign meta.frame_command = command_next;
    assign meta.frame_length  = length_next;
    assign meta.read_valid    = read_hit;

endmodule

FILE: design/xcpd_store.sv
module xcpd_store (
    input  logic                  aclk,
    input  logic                  accept,
    input  xcpd_pkg::store_req_t  store_req,
    output logic [7:0]            rd_data
);

    logic [7:0] mem [xcpd_pkg::PAYLOAD_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (accept && store_req.wr_en) begin
            mem[store_req.wr_addr] <= store_req.wr_data;
        end
        if (accept && store_req.rd_en) begin
            rd_data_reg <= mem[store_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/xor_checked_packet_deframer_top.sv
// Byte-stream frame parser with an XOR checksum and a payload buffer.
// Each input request on the s_ channel carries a command in s_tuser: feed
// the byte in s_tdata[7:0], clear the parser, or read the payload byte at
// s_tdata[15:8]. A frame is a command byte, a length byte, that many payload
// bytes and a checksum byte equal to the XOR of all earlier frame bytes.
// Every request yields exactly one result request on the m_ channel with
// the parser status after that request, the held command and length, and
// on a read the payload byte with its valid flag in m_tuser.
// A request is accepted every cycle while the receiver keeps m_tready high.
// A result goes through the middle stage, then the output register: the
// parser updates and the payload memory read port launches on the accept
// edge; the registered read data joins the output register as it advances.
// When the receiver stalls, the output register and the middle stage both
// hold, and s_tready drops only once both are occupied.
// Reset clears the parser to await command and empties both stages; the
// payload buffer keeps whatever it held and is meaningful only after a
// frame that passed its checksum.
module xor_checked_packet_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // byte_in[7:0], read_index[15:8]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[2:0], frame_command[10:3],
                                   // frame_length[18:11], read_byte[26:19], zero[31:27]
    output logic        m_tuser    // read_valid
);

    logic                 accept;
    logic                 advance;
    xcpd_pkg::meta_t      meta;
    xcpd_pkg::store_req_t store_req;
    logic [7:0]           rd_data;

    logic                 mid_valid_reg;
    xcpd_pkg::meta_t      mid_meta_reg;
    logic                 out_valid_reg;
    xcpd_pkg::meta_t      out_meta_reg;
    logic [7:0]           out_byte_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !mid_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    xcpd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .cmd        (s_tuser),
        .byte_in    (s_tdata[7:0]),
        .read_index (s_tdata[15:8]),
        .meta       (meta),
        .store_req  (store_req)
    );

    xcpd_store u_store (
        .aclk      (aclk),
        .accept    (accept),
        .store_req (store_req),
        .rd_data   (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                mid_valid_reg <= 1'b1;
            end else if (advance) begin
                mid_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mid_meta_reg <= meta;
        end
        if (advance && mid_valid_reg) begin
            out_meta_reg <= mid_meta_reg;
            out_byte_reg <= mid_meta_reg.read_valid ? rd_data : 8'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_byte_reg, out_meta_reg.frame_length,
                       out_meta_reg.frame_command, out_meta_reg.status};
    assign m_tuser  = out_meta_reg.read_valid;

endmodule

FILE: design/xcpd_checker.sv
module xcpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // The output channel is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A valid read is only reported with the parser in the finished phase.
    a_read_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[2:0] == xcpd_pkg::ST_FINISHED)
        else $error("read valid outside finished phase");

    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[26:19] == 8'd0)
        else $error("read byte nonzero without read valid");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:27] == 5'd0 && m_tdata[2:0] <= xcpd_pkg::ST_FAILED)
        else $error("status out of range or padding set");

endmodule

bind xor_checked_packet_deframer_top xcpd_checker u_xcpd_checker (.*);

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xcpd_pkg::*;

    localparam int RANDOM_REQUESTS = 1450;
    localparam int CYCLE_LIMIT = 120000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        status_t    status;
        logic [7:0] fcmd;
        logic [7:0] flen;
        logic [7:0] rbyte;
        logic       rvalid;
    } frame_result_t;

    typedef struct packed {
        cmd_t          cmd;
        logic [7:0]    data;
        logic [7:0]    idx;
        logic          typed;
        frame_result_t want;
    } script_row_t;

    localparam frame_result_t CLEARED = '{ST_COMMAND, 8'h00, 8'h00, 8'h00, 1'b0};
    localparam frame_result_t BAD_FRAME = '{ST_FAILED, 8'h00, 8'h01, 8'h00, 1'b0};
    localparam int SCRIPT_LEN = 25;

    // Rows with typed set carry a result that is known by inspection; the
    // others take their expected result from the parser copy below.
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{CMD_NONE,  8'h00, 8'h00, 1'b1, CLEARED},
        '{CMD_FEED,  8'hFF, 8'h00, 1'b1, '{ST_LENGTH, 8'hFF, 8'h00, 8'h00, 1'b0}},
        '{CMD_FEED,  8'h00, 8'h00, 1'b1, '{ST_CHECKSUM, 8'hFF, 8'h00, 8'h00, 1'b0}},
        '{CMD_FEED,  8'hFF, 8'h00, 1'b1, '{ST_FINISHED, 8'hFF, 8'h00, 8'h00, 1'b0}},
        '{CMD_FEED,  8'h12, 8'hFF, 1'b1, '{ST_FINISHED, 8'hFF, 8'h00, 8'h00, 1'b0}},
        '{CMD_CLEAR, 8'hFF, 8'hFF, 1'b1, CLEARED},
        '{CMD_FEED,  8'hA5, 8'h00, 1'b0, CLEARED},
        '{CMD_FEED,  8'h03, 8'h00, 1'b0, CLEARED},
        '{CMD_FEED,  8'h00, 8'h00, 1'b0, CLEARED},
        '{CMD_FEED,  8'hFF, 8'h00, 1'b0, CLEARED},
        '{CMD_NONE,  8'h00, 8'h00, 1'b0, CLEARED},
        '{CMD_FEED,  8'h5A, 8'h00, 1'b0, CLEARED},
        '{CMD_FEED,  8'h03, 8'h00, 1'b0, CLEARED},
        '{CMD_READ,  8'h00, 8'h00, 1'b0, CLEARED},
        '{CMD_READ,  8'hFF, 8'h02, 1'b0, CLEARED},
        '{CMD_FEED,  8'h77, 8'h00, 1'b0, CLEARED},
        '{CMD_CLEAR, 8'h00, 8'h00, 1'b1, CLEARED},
        '{CMD_FEED,  8'h00, 8'h00, 1'b0, CLEARED},
        '{CMD_FEED,  8'h01, 8'h00, 1'b0, CLEARED},
        '{CMD_READ,  8'h00, 8'h00, 1'b0, CLEARED},
        '{CMD_FEED,  8'h77, 8'h00, 1'b0, CLEARED},
        '{CMD_FEED,  8'h00, 8'h00, 1'b1, BAD_FRAME},
        '{CMD_FEED,  8'h76, 8'h00, 1'b1, BAD_FRAME},
        '{CMD_READ,  8'h00, 8'h00, 1'b1, BAD_FRAME},
        '{CMD_CLEAR, 8'h00, 8'h00, 1'b1, CLEARED}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic [1:0]  s_tuser = CMD_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    status_t     parse_phase = ST_COMMAND;
    logic [7:0]  held_cmd = 8'h00;
    logic [7:0]  held_len = 8'h00;
    logic [7:0]  payload_left = 8'h00;
    logic [7:0]  xor_acc = 8'h00;
    logic [7:0]  payload_copy [PAYLOAD_DEPTH];

    frame_result_t pending_results [$];
    int unsigned   mismatches = 0;
    int unsigned   accepted = 0;
    int unsigned   cycles = 0;
    bit            quiet = 1'b0;

    xor_checked_packet_deframer_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic frame_result_t parse_request(input cmd_t cmd, input logic [7:0] data,
                                                    input logic [7:0] idx);
        frame_result_t r;
        logic [7:0]    slot;
        r = CLEARED;
        case (cmd)
            CMD_FEED: begin
                case (parse_phase)
                    ST_COMMAND: begin
                        held_cmd = data;
                        xor_acc ^= data;
                        parse_phase = ST_LENGTH;
                    end
                    ST_LENGTH: begin
                        held_len = data;
                        payload_left = data;
                        xor_acc ^= data;
                        if ({1'b0, data} > DEPTH_9) begin
                            parse_phase = ST_FAILED;
                        end else if (data == 8'h00) begin
                            parse_phase = ST_CHECKSUM;
                        end else begin
                            parse_phase = ST_PAYLOAD;
                        end
                    end
                    ST_PAYLOAD: begin
                        slot = held_len - payload_left;
                        if (int'(slot) < PAYLOAD_DEPTH) begin
                            payload_copy[slot] = data;
                        end
                        xor_acc ^= data;
                        if (payload_left != 8'h00) begin
                            payload_left = payload_left - 8'h01;
                        end
                        if (payload_left == 8'h00) begin
                            parse_phase = ST_CHECKSUM;
                        end
                    end
                    ST_CHECKSUM: begin
                        parse_phase = (xor_acc == data) ? ST_FINISHED : ST_FAILED;
                    end
                    default: begin
                    end
                endcase
            end
            CMD_CLEAR: begin
                parse_phase = ST_COMMAND;
                held_cmd = 8'h00;
                held_len = 8'h00;
                payload_left = 8'h00;
                xor_acc = 8'h00;
            end
            CMD_READ: begin
                if (parse_phase == ST_FINISHED && idx < held_len && int'(idx) < PAYLOAD_DEPTH) begin
                    r.rbyte = payload_copy[idx];
                    r.rvalid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.status = parse_phase;
        r.fcmd = held_cmd;
        r.flen = held_len;
        return r;
    endfunction

    task automatic push_request(input cmd_t cmd, input logic [7:0] data, input logic [7:0] idx,
                                input logic typed, input frame_result_t want);
        frame_result_t predicted;
        while (!quiet && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {idx, data};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = parse_request(cmd, data, idx);
        pending_results.push_back(typed ? want : predicted);
        accepted++;
    endtask

    task automatic check_field(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s expected %h, got %h", $time, what, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end

    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with none expected, got %h user %b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 8'(want.status), 8'(m_tdata[2:0]));
                check_field("frame_command", want.fcmd, m_tdata[10:3]);
                check_field("frame_length", want.flen, m_tdata[18:11]);
                check_field("read_byte", want.rbyte, m_tdata[26:19]);
                check_field("read_valid", 8'(want.rvalid), 8'(m_tuser));
                check_field("tdata padding", 8'h00, 8'(m_tdata[31:27]));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL xor_checked_packet_deframer_top");
            $finish;
        end
    end

    initial begin
        int          roll;
        int          frame_no;
        logic [7:0]  len;
        logic [7:0]  chk;
        frame_no = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            push_request(SCRIPT[i].cmd, SCRIPT[i].data, SCRIPT[i].idx, SCRIPT[i].typed,
                         SCRIPT[i].want);
        end

        // Mostly well-formed frames with random content, some corrupted,
        // with reads afterwards; the rest is read bursts and random noise.
        while (accepted < SCRIPT_LEN + RANDOM_REQUESTS) begin
            quiet = (accepted > 600 && accepted < 900);
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                if (parse_phase != ST_COMMAND || $urandom_range(0, 3) == 0) begin
                    push_request(CMD_CLEAR, 8'($urandom), 8'($urandom), 1'b0, CLEARED);
                end
                frame_no++;
                if (frame_no == 1) begin
                    len = 8'hFF;
                end else if (frame_no % 50 == 0) begin
                    len = 8'($urandom_range(128, 255));
                end else begin
                    len = 8'($urandom_range(0, 12));
                end
                push_request(CMD_FEED, 8'($urandom), 8'($urandom), 1'b0, CLEARED);
                push_request(CMD_FEED, len, 8'($urandom), 1'b0, CLEARED);
                for (int k = 0; k < int'(len); k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        push_request(cmd_t'($urandom_range(2, 3)), 8'($urandom), 8'($urandom),
                                     1'b0, CLEARED);
                    end
                    push_request(CMD_FEED, 8'($urandom), 8'($urandom), 1'b0, CLEARED);
                end
                chk = xor_acc;
                if ($urandom_range(0, 6) == 0) begin
                    chk ^= 8'($urandom_range(1, 255));
                end
                push_request(CMD_FEED, chk, 8'($urandom), 1'b0, CLEARED);
                repeat ($urandom_range(0, 2)) begin
                    push_request(CMD_FEED, 8'($urandom), 8'($urandom), 1'b0, CLEARED);
                end
                repeat ($urandom_range(1, 6)) begin
                    push_request(CMD_READ, 8'($urandom),
                                 (held_len != 8'h00 && $urandom_range(0, 3) != 0) ?
                                     8'($urandom_range(0, int'(held_len) - 1)) : 8'($urandom),
                                 1'b0, CLEARED);
                end
            end else if (roll < 85) begin
                repeat ($urandom_range(1, 8)) begin
                    push_request(CMD_READ, 8'($urandom), 8'($urandom), 1'b0, CLEARED);
                end
            end else begin
                push_request(cmd_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                             1'b0, CLEARED);
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS xor_checked_packet_deframer_top");
        end else begin
            $display("FAIL xor_checked_packet_deframer_top");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/xcpd_pkg.sv
design/xcpd_parser.sv
design/xcpd_store.sv
design/xor_checked_packet_deframer_top.sv
design/xcpd_checker.sv
sim/testbench.sv
